FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dqbl_pkg.sv
// ----------------------------------------------------------------------------
// dqbl_pkg
// Types and constants of the two-ring priority queue with burst limit.
// ----------------------------------------------------------------------------
package dqbl_pkg;

  localparam int unsigned PRIO_DEPTH = 64;
  localparam int unsigned NORM_DEPTH = 64;

  localparam int unsigned P_IDXW = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
  localparam int unsigned N_IDXW = (NORM_DEPTH > 1) ? $clog2(NORM_DEPTH) : 1;
  localparam int unsigned P_CNTW = $clog2(PRIO_DEPTH + 1);
  localparam int unsigned N_CNTW = $clog2(NORM_DEPTH + 1);
  localparam int unsigned IDXW   = (P_IDXW > N_IDXW) ? P_IDXW : N_IDXW;
  localparam int unsigned CNTW   = (P_CNTW > N_CNTW) ? P_CNTW : N_CNTW;

  localparam int unsigned KIND_W    = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned BURST_W   = 8;

  localparam logic [KIND_W-1:0]  KIND_COLLISION    = 4'd4;
  localparam logic [KIND_W-1:0]  KIND_RENDER       = 4'd5;
  localparam logic [BURST_W-1:0] BURST_LIMIT_RESET = 8'd16;
  localparam logic [BURST_W-1:0] BURST_MAX         = 8'hFF;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_POP_NP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_START = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_SHWR  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [KIND_W-1:0]    kind;
    logic                 staged;
    logic [PAYLOAD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [KIND_W-1:0]    out_kind;
    logic                 out_staged;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 from_priority;
    logic                 backlog;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 staged;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

FILE: src/dual_queue_burst_limited_priority.sv
// ----------------------------------------------------------------------------
// dual_queue_burst_limited_priority
// Two ring FIFOs (priority and normal) with a burst-limited pop arbiter and
// a non-payload pop that searches and compacts the rings.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o, in_data_i): one command item - push,
//     pop by priority rule, pop oldest non-payload entry (priority ring first), or no-op.
//   out channel (out_valid_o/out_ready_i, out_data_o): exactly one result
//     item per command item, in order.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_data_i): writes burst_limit;
//     always ready, write only while the block is idle.
// Sequencing: push and no-op go from idle to S_OUT, which loads the output
//   register; a plain pop passes S_POP first (one registered ring read).
//   A non-payload pop runs S_START and S_CHK per entry scanned, S_SHIFT and
//   S_SHWR per younger entry shifted down, over one read and one write port.
// Throughput: one item at a time; in_ready_o is high only in the idle state.
// Reset: counts, heads and burst count clear, burst_limit becomes 16; ring
//   storage is not cleared, entries outside a count are never used.
// Stall: a finished result waits in the output register; the block may take
//   the next item meanwhile and holds its next result until the slot frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_queue_burst_limited_priority import dqbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [BURST_W-1:0]   cfg_data_i
);

  localparam int unsigned P_SUMW = P_IDXW + 1;
  localparam int unsigned N_SUMW = N_IDXW + 1;

  function automatic logic [P_IDXW-1:0] p_inc(input logic [P_IDXW-1:0] a);
    p_inc = (a == P_IDXW'(PRIO_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [N_IDXW-1:0] n_inc(input logic [N_IDXW-1:0] a);
    n_inc = (a == N_IDXW'(NORM_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [P_IDXW-1:0] p_tail(input logic [P_IDXW-1:0] h,
                                               input logic [P_CNTW-1:0] c);
    logic [P_SUMW-1:0] s;
    s = P_SUMW'(h) + P_SUMW'(c);
    if (s >= P_SUMW'(PRIO_DEPTH)) s = s - P_SUMW'(PRIO_DEPTH);
    p_tail = s[P_IDXW-1:0];
  endfunction

  function automatic logic [N_IDXW-1:0] n_tail(input logic [N_IDXW-1:0] h,
                                               input logic [N_CNTW-1:0] c);
    logic [N_SUMW-1:0] s;
    s = N_SUMW'(h) + N_SUMW'(c);
    if (s >= N_SUMW'(NORM_DEPTH)) s = s - N_SUMW'(NORM_DEPTH);
    n_tail = s[N_IDXW-1:0];
  endfunction

  // Ring storage
  entry_t p_mem [PRIO_DEPTH];
  entry_t n_mem [NORM_DEPTH];
  entry_t p_rdata_q, n_rdata_q;
  logic              p_we, n_we;
  logic [P_IDXW-1:0] p_waddr, p_raddr;
  logic [N_IDXW-1:0] n_waddr, n_raddr;
  entry_t            wdata;

  // Control state
  state_e              state_q, state_d;
  logic [P_IDXW-1:0]   p_head_q, p_head_d;
  logic [N_IDXW-1:0]   n_head_q, n_head_d;
  logic [P_CNTW-1:0]   p_cnt_q, p_cnt_d;
  logic [N_CNTW-1:0]   n_cnt_q, n_cnt_d;
  logic [BURST_W-1:0]  burst_q, burst_d;
  logic [BURST_W-1:0]  limit_q, limit_d;
  logic                ring_q, ring_d;       // 1: working on the priority ring
  logic [IDXW-1:0]     addr_q, addr_d;
  logic [CNTW-1:0]     off_q, off_d;
  logic                out_valid_q, out_valid_d;

  // Result holding registers
  status_e             res_status_q, res_status_d;
  entry_t              res_entry_q, res_entry_d;
  logic                res_prio_q, res_prio_d;
  out_item_t           out_q;
  logic                out_load;

  logic                in_fire;
  cmd_e                cmd;
  logic                route_prio;
  logic                ring_full;
  logic                serve_norm;
  entry_t              cur_rdata;
  logic [CNTW-1:0]     cur_cnt;
  logic [IDXW-1:0]     addr_inc;
  logic [BURST_W-1:0]  burst_inc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(in_data_i.command);
  assign route_prio = (in_data_i.kind <= KIND_COLLISION) ||
                      ((in_data_i.kind == KIND_RENDER) && in_data_i.staged);
  assign ring_full  = route_prio ? (p_cnt_q == P_CNTW'(PRIO_DEPTH))
                                 : (n_cnt_q == N_CNTW'(NORM_DEPTH));
  assign serve_norm = (n_cnt_q != '0) && ((p_cnt_q == '0) || (burst_q >= limit_q));

  assign cur_rdata = ring_q ? p_rdata_q : n_rdata_q;
  assign cur_cnt   = ring_q ? CNTW'(p_cnt_q) : CNTW'(n_cnt_q);
  assign addr_inc  = ring_q ? IDXW'(p_inc(addr_q[P_IDXW-1:0]))
                            : IDXW'(n_inc(addr_q[N_IDXW-1:0]));
  assign burst_inc = (burst_q == BURST_MAX) ? burst_q : burst_q + 1'b1;

  // Read at the head while idle, at the scan pointer while searching, and one
  // past it while shifting.
  always_comb begin
    p_raddr = p_head_q;
    n_raddr = n_head_q;
    if (state_q == S_SHIFT) begin
      p_raddr = addr_inc[P_IDXW-1:0];
      n_raddr = addr_inc[N_IDXW-1:0];
    end else if (state_q != S_IDLE) begin
      p_raddr = addr_q[P_IDXW-1:0];
      n_raddr = addr_q[N_IDXW-1:0];
    end
  end

  always_comb begin
    if (state_q == S_SHWR) begin
      p_waddr = addr_q[P_IDXW-1:0];
      n_waddr = addr_q[N_IDXW-1:0];
      wdata   = cur_rdata;
    end else begin
      p_waddr = p_tail(p_head_q, p_cnt_q);
      n_waddr = n_tail(n_head_q, n_cnt_q);
      wdata   = '{kind: in_data_i.kind, staged: in_data_i.staged,
                  payload: in_data_i.payload};
    end
  end

  always_comb begin
    state_d      = state_q;
    p_head_d     = p_head_q;
    n_head_d     = n_head_q;
    p_cnt_d      = p_cnt_q;
    n_cnt_d      = n_cnt_q;
    burst_d      = burst_q;
    limit_d      = limit_q;
    ring_d       = ring_q;
    addr_d       = addr_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    res_prio_d   = res_prio_q;
    p_we         = 1'b0;
    n_we         = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cfg_valid_i) limit_d = cfg_data_i;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_DONE;
          res_entry_d  = '0;
          res_prio_d   = 1'b0;
          state_d      = S_OUT;
          case (cmd)
            CMD_PUSH: begin
              res_prio_d = route_prio;
              if (ring_full) begin
                res_status_d = ST_FULL;
              end else if (route_prio) begin
                p_we    = 1'b1;
                p_cnt_d = p_cnt_q + 1'b1;
              end else begin
                n_we    = 1'b1;
                n_cnt_d = n_cnt_q + 1'b1;
              end
            end
            CMD_POP: begin
              ring_d = !serve_norm;
              if (!serve_norm && (p_cnt_q == '0)) begin
                res_status_d = ST_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            CMD_POP_NP: begin
              ring_d  = 1'b1;
              addr_d  = IDXW'(p_head_q);
              off_d   = '0;
              state_d = S_START;
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        res_entry_d = cur_rdata;
        res_prio_d  = ring_q;
        if (ring_q) begin
          p_head_d = p_inc(p_head_q);
          p_cnt_d  = p_cnt_q - 1'b1;
          burst_d  = burst_inc;
        end else begin
          n_head_d = n_inc(n_head_q);
          n_cnt_d  = n_cnt_q - 1'b1;
          burst_d  = '0;
        end
        state_d = S_OUT;
      end

      // Issue the read of the entry at the scan pointer, or move on when the
      // ring is exhausted: to the normal ring, or out with an empty status.
      S_START: begin
        if (off_q >= cur_cnt) begin
          if (ring_q) begin
            ring_d = 1'b0;
            addr_d = IDXW'(n_head_q);
            off_d  = '0;
          end else begin
            res_status_d = ST_EMPTY;
            state_d      = S_OUT;
          end
        end else begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if ((cur_rdata.kind == KIND_COLLISION) || (cur_rdata.kind == KIND_RENDER)) begin
          addr_d  = addr_inc;
          off_d   = off_q + 1'b1;
          state_d = S_START;
        end else begin
          res_entry_d = cur_rdata;
          res_prio_d  = ring_q;
          state_d     = S_SHIFT;
        end
      end

      // Close the gap one entry at a time: read the younger neighbor here,
      // write it one place toward the head in S_SHWR.
      S_SHIFT: begin
        if ((CNTW + 1)'(off_q) + 1'b1 >= (CNTW + 1)'(cur_cnt)) begin
          if (ring_q) begin
            p_cnt_d = p_cnt_q - 1'b1;
            burst_d = burst_inc;
          end else begin
            n_cnt_d = n_cnt_q - 1'b1;
            burst_d = '0;
          end
          state_d = S_OUT;
        end else begin
          state_d = S_SHWR;
        end
      end

      S_SHWR: begin
        p_we    = ring_q;
        n_we    = !ring_q;
        addr_d  = addr_inc;
        off_d   = off_q + 1'b1;
        state_d = S_SHIFT;
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_head_q     <= '0;
      n_head_q     <= '0;
      p_cnt_q      <= '0;
      n_cnt_q      <= '0;
      burst_q      <= '0;
      limit_q      <= BURST_LIMIT_RESET;
      ring_q       <= 1'b0;
      addr_q       <= '0;
      off_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_DONE;
      res_prio_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      p_head_q     <= p_head_d;
      n_head_q     <= n_head_d;
      p_cnt_q      <= p_cnt_d;
      n_cnt_q      <= n_cnt_d;
      burst_q      <= burst_d;
      limit_q      <= limit_d;
      ring_q       <= ring_d;
      addr_q       <= addr_d;
      off_q        <= off_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      res_prio_q   <= res_prio_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_entry_q <= res_entry_d;
    if (out_load) begin
      out_q <= '{status:        res_status_q,
                 out_kind:      res_entry_q.kind,
                 out_staged:    res_entry_q.staged,
                 out_payload:   res_entry_q.payload,
                 from_priority: res_prio_q,
                 backlog:       (p_cnt_q != '0) || (n_cnt_q != '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) p_mem[p_waddr] <= wdata;
    p_rdata_q <= p_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) n_mem[n_waddr] <= wdata;
    n_rdata_q <= n_mem[n_raddr];
  end

  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1,
    (p_cnt_q <= P_CNTW'(PRIO_DEPTH)) && (n_cnt_q <= N_CNTW'(NORM_DEPTH)),
    "ring count beyond depth")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o,
    "block ready right after taking an item")
  `ASSERT_NEXT(a_push_grows, clk_i, rst_ni,
    in_fire && (cmd == CMD_PUSH) && route_prio && !ring_full,
    p_cnt_q == $past(p_cnt_q) + 1'b1, "accepted priority push not counted")
  `ASSERT_IMPL(a_write_source, clk_i, rst_ni, p_we || n_we,
    (state_q == S_SHWR) || ((state_q == S_IDLE) && in_fire && (cmd == CMD_PUSH)),
    "ring written outside push or shift")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the two-ring priority queue with burst limit. Items go in
// through the command channel and results are checked in order against a
// cycle-free predictor of both rings, the burst counter and the limit.
// ----------------------------------------------------------------------------
module tb;
  import dqbl_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRESSURE_HOLD = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_PRINTS    = 40;
  localparam int PHASE_ITEMS   = 55;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [BURST_W-1:0] cfg_data_i;

  // Predicted contents of both rings, oldest entry first.
  entry_t             prio_ring_q[$];
  entry_t             norm_ring_q[$];
  logic [BURST_W-1:0] burst_run;
  logic [BURST_W-1:0] burst_limit_q;
  out_item_t          owed_results[$];

  int unsigned mismatches = 0;
  bit          idle_on    = 1'b1;
  bit          hold_req   = 1'b0;

  dual_queue_burst_limited_priority DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int first_plain(input entry_t ring[$]);
    foreach (ring[i])
      if (ring[i].kind != KIND_COLLISION && ring[i].kind != KIND_RENDER) return i;
    return -1;
  endfunction

  function automatic void bump_burst();
    if (burst_run != BURST_MAX) burst_run++;
  endfunction

  function automatic out_item_t apply_command(input in_item_t item);
    out_item_t res;
    entry_t    got;
    logic      to_prio;
    logic      take_norm;
    int        idx;
    res = '0;
    got = '0;
    case (item.command)
      CMD_PUSH: begin
        to_prio = (item.kind <= KIND_COLLISION) || (item.kind == KIND_RENDER && item.staged);
        res.from_priority = to_prio;
        if (to_prio ? prio_ring_q.size() >= PRIO_DEPTH : norm_ring_q.size() >= NORM_DEPTH) begin
          res.status = ST_FULL;
        end else if (to_prio) begin
          prio_ring_q.push_back('{kind: item.kind, staged: item.staged, payload: item.payload});
        end else begin
          norm_ring_q.push_back('{kind: item.kind, staged: item.staged, payload: item.payload});
        end
      end
      CMD_POP: begin
        take_norm = norm_ring_q.size() != 0 &&
                    (prio_ring_q.size() == 0 || burst_run >= burst_limit_q);
        if (take_norm) begin
          got = norm_ring_q.pop_front();
          burst_run = '0;
        end else if (prio_ring_q.size() != 0) begin
          got = prio_ring_q.pop_front();
          bump_burst();
          res.from_priority = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_POP_NP: begin
        idx = first_plain(prio_ring_q);
        if (idx >= 0) begin
          got = prio_ring_q[idx];
          prio_ring_q.delete(idx);
          bump_burst();
          res.from_priority = 1'b1;
        end else begin
          idx = first_plain(norm_ring_q);
          if (idx >= 0) begin
            got = norm_ring_q[idx];
            norm_ring_q.delete(idx);
            burst_run = '0;
          end else begin
            res.status = ST_EMPTY;
          end
        end
      end
      default: ;
    endcase
    res.out_kind    = got.kind;
    res.out_staged  = got.staged;
    res.out_payload = got.payload;
    res.backlog     = (prio_ring_q.size() != 0) || (norm_ring_q.size() != 0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders and idle lengths
  // --------------------------------------------------------------------------
  function automatic in_item_t make_item(input cmd_e cmd, input logic [KIND_W-1:0] kind,
                                         input logic staged, input logic [PAYLOAD_W-1:0] payload);
    return '{command: cmd, kind: kind, staged: staged, payload: payload};
  endfunction

  function automatic in_item_t prio_push();
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(0, 5));
    return make_item(CMD_PUSH, k, (k == KIND_RENDER) ? 1'b1 : 1'($urandom_range(0, 1)),
                     $urandom());
  endfunction

  function automatic in_item_t norm_push();
    logic [KIND_W-1:0] k;
    k = KIND_W'($urandom_range(5, 15));
    return make_item(CMD_PUSH, k, (k == KIND_RENDER) ? 1'b0 : 1'($urandom_range(0, 1)),
                     $urandom());
  endfunction

  function automatic in_item_t random_item(input int push_pct, input int np_pct,
                                           input int nop_pct);
    int   r;
    cmd_e cmd;
    r = $urandom_range(0, 99);
    if (r < push_pct) cmd = CMD_PUSH;
    else if (r < push_pct + np_pct) cmd = CMD_POP_NP;
    else if (r < push_pct + np_pct + nop_pct) cmd = CMD_NOP;
    else cmd = CMD_POP;
    return make_item(cmd, KIND_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     $urandom());
  endfunction

  // Mostly short, now and then long.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Channel tasks
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t item);
    int gap;
    gap = (!idle_on || $urandom_range(0, 99) < 55) ? 0 : gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    owed_results.push_back(apply_command(item));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_burst_limit(input logic [BURST_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    burst_limit_q = value;
  endtask

  task automatic drain_rings();
    while (prio_ring_q.size() + norm_ring_q.size() != 0)
      send_item(make_item(($urandom_range(0, 9) == 0) ? CMD_POP_NP : CMD_POP,
                          KIND_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom()));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing owed", out_data_o.out_payload, '0);
      end else begin
        want = owed_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.out_kind !== want.out_kind)
          report_mismatch("out_kind", out_data_o.out_kind, want.out_kind);
        if (out_data_o.out_staged !== want.out_staged)
          report_mismatch("out_staged", out_data_o.out_staged, want.out_staged);
        if (out_data_o.out_payload !== want.out_payload)
          report_mismatch("out_payload", out_data_o.out_payload, want.out_payload);
        if (out_data_o.from_priority !== want.from_priority)
          report_mismatch("from_priority", out_data_o.from_priority, want.from_priority);
        if (out_data_o.backlog !== want.backlog)
          report_mismatch("backlog", out_data_o.backlog, want.backlog);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!idle_on || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = gap_length() - 1;
        out_ready_i <= 1'b0;
      end
    end
  end

  // End the run once no channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("dual_queue_burst_limited_priority regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_block();
    send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
    send_item(make_item(CMD_POP_NP, 4'd15, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_NOP, 4'd9, 1'b1, 32'h1234_5678));
  endtask

  task automatic test_routing_and_fields();
    logic [PAYLOAD_W-1:0] patterns[4];
    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    // Every kind, 14 and 15 included; kind 5 staged, then once more staged.
    for (int k = 0; k < 16; k++)
      send_item(make_item(CMD_PUSH, KIND_W'(k), k[0], patterns[k % 4]));
    send_item(make_item(CMD_PUSH, KIND_RENDER, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_POP_NP, 4'd0, 1'b0, 32'h0));
    send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
    send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
    send_item(make_item(CMD_NOP, 4'd0, 1'b0, 32'h0));
  endtask

  task automatic test_full_rings();
    repeat (PRIO_DEPTH - prio_ring_q.size() + 2) send_item(prio_push());
    repeat (NORM_DEPTH - norm_ring_q.size() + 2) send_item(norm_push());
    send_item(make_item(CMD_POP_NP, 4'd0, 1'b0, 32'h0));
    drain_rings();
  endtask

  task automatic test_payload_only_rings();
    // Only collision and render entries waiting: the search finds nothing.
    send_item(make_item(CMD_PUSH, KIND_COLLISION, 1'b0, $urandom()));
    send_item(make_item(CMD_PUSH, KIND_RENDER, 1'b1, $urandom()));
    send_item(make_item(CMD_PUSH, KIND_RENDER, 1'b0, $urandom()));
    send_item(make_item(CMD_POP_NP, 4'd0, 1'b0, 32'h0));
    drain_rings();
  endtask

  task automatic test_burst_saturation();
    write_burst_limit(BURST_MAX);
    // Over 255 priority pops in a row with the normal ring empty.
    for (int round = 0; round < 4; round++) begin
      idle_on = (round % 2) != 0;
      repeat (PRIO_DEPTH) send_item(prio_push());
      repeat (PRIO_DEPTH) send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
    end
    idle_on = 1'b1;
    send_item(norm_push());
    send_item(prio_push());
    send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
    send_item(make_item(CMD_POP, 4'd0, 1'b0, 32'h0));
  endtask

  task automatic test_random_phases();
    logic [BURST_W-1:0] limits[5];
    int                 push_pct;
    limits = '{8'd0, 8'd1, BURST_MAX, BURST_W'($urandom_range(2, 254)), BURST_LIMIT_RESET};
    for (int phase = 0; phase < 5; phase++) begin
      write_burst_limit(limits[phase]);
      idle_on  = (phase != 1);
      push_pct = (phase == 2) ? 70 : $urandom_range(40, 60);
      // Hold the receiver so the block backs up and stalls its input.
      if (phase == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item(push_pct, 15, 5));
    end
    idle_on = 1'b1;
    drain_rings();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    burst_run     = '0;
    burst_limit_q = BURST_LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_block();
    test_routing_and_fields();
    test_full_rings();
    test_payload_only_rings();
    test_burst_saturation();
    test_random_phases();

    wait_idle();
    if (mismatches == 0) begin
      $display("dual_queue_burst_limited_priority regression: pass");
    end else begin
      $display("dual_queue_burst_limited_priority regression: fail");
    end
    $finish;
  end

endmodule
